>>> sv/spq_pkg.sv
package spq_pkg;

   localparam int DEPTH  = 128;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ID_W   = 16;
   localparam int COST_W = 16;
   localparam int OCC_W  = 8;
   localparam int STAT_W = 2;

   localparam logic REQ_ENQ = 1'b0;
   localparam logic REQ_DEQ = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [COST_W-1:0] cost;
   } entry_type;

   // Shift command broadcast to every cell of the chain.
   typedef struct packed {
      logic enq_go;
      logic deq_go;
   } shift_ctrl_type;

endpackage

>>> sv/spq_cell.sv
module spq_cell
   import spq_pkg::*;
(
   input  logic           clock,
   input  shift_ctrl_type ctrl,
   input  entry_type      new_entry,
   input  logic           occupied,
   input  entry_type      left_entry,
   input  logic           left_gt,
   input  entry_type      right_entry,
   output entry_type      entry,
   output logic           gt
);

   entry_type entry_ff;
   entry_type entry_in;

   // The stored cost is strictly above the new one, so the new entry goes in front.
   assign gt    = occupied && (entry_ff.cost > new_entry.cost);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.enq_go) begin
         if (left_gt) begin
            entry_in = left_entry;
         end else if (gt || !occupied) begin
            entry_in = new_entry;
         end
      end else if (ctrl.deq_go) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> sv/sorted_priority_queue_unit.sv
// A result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle while results are taken; every cell of the chain
// compares and shifts in the same cycle, and the single result register sets the pace.
// Reset (synchronous, active high) empties the queue and drops any pending result;
// the cell contents are left as they are and only become visible once written.
module sorted_priority_queue_unit
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [15:0] job_id, [31:16] job_cost
   input  logic [0:0]  req_tuser,  // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [15:0] out_id, [31:16] out_cost, [39:32] occupancy
   output logic [1:0]  rsp_tuser   // [1:0] status
);

   // Number of stored jobs. Cell i holds a live entry exactly when i < count.
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   entry_type         rsp_entry_ff, rsp_entry_in;
   logic [OCC_W-1:0]  rsp_occ_ff, rsp_occ_in;

   logic           req_fire;
   logic           is_full;
   logic           is_empty;
   entry_type      new_entry;
   shift_ctrl_type ctrl;

   entry_type cell_entry [DEPTH];
   logic      cell_gt    [DEPTH];
   logic      cell_occ   [DEPTH];

   // The result register frees up in the same cycle its beat is taken,
   // so requests can stream without a bubble.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign new_entry.id   = req_tdata[ID_W-1:0];
   assign new_entry.cost = req_tdata[ID_W+COST_W-1:ID_W];

   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   // A rejected request (full on insert, empty on removal) leaves the chain alone.
   assign ctrl.enq_go = req_fire && (req_tuser[0] == REQ_ENQ) && !is_full;
   assign ctrl.deq_go = req_fire && (req_tuser[0] == REQ_DEQ) && !is_empty;

   // The chain: on an insert every cell looks at its left neighbor's compare
   // and either takes the neighbor's entry, the new entry or keeps its own.
   // On a removal every cell takes the entry of its right neighbor.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      logic      left_gt;
      entry_type right_entry;

      assign cell_occ[i] = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign left_gt    = 1'b0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .occupied    (cell_occ[i]),
         .left_entry  (left_entry),
         .left_gt     (left_gt),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .gt          (cell_gt[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_occ_in    = rsp_occ_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (ctrl.enq_go) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.deq_go) begin
         count_in = count_ff - CNT_W'(1);
      end

      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_entry_in = '0;
         rsp_occ_in   = OCC_W'(count_in);
         if (req_tuser[0] == REQ_ENQ) begin
            rsp_status_in = is_full ? ST_FULL : ST_OK;
         end else if (is_empty) begin
            rsp_status_in = ST_EMPTY;
         end else begin
            // The head cell always holds the cheapest, oldest job.
            rsp_status_in = ST_OK;
            rsp_entry_in  = cell_entry[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_occ_ff, rsp_entry_ff.cost, rsp_entry_ff.id};
   assign rsp_tuser  = rsp_status_ff;

   // The count never runs past the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // The two front cells stay in ascending cost order.
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> (cell_entry[0].cost <= cell_entry[1].cost))
      else $error("head entries out of order");

   // An accepted insert grows the queue by one.
   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.enq_go |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the queue");

   // A rejected request leaves the count alone and reports a failure status.
   a_reject: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !ctrl.enq_go && !ctrl.deq_go) |=>
         ($stable(count_ff) && (rsp_status_ff != ST_OK)))
      else $error("rejected request changed the queue");

endmodule

>>> tb/sv/sorted_priority_queue_unit_test.sv
module sorted_priority_queue_unit_test;
   import spq_pkg::*;

   // Watchdog limit in cycles without any accepted beat on either side.
   localparam int STALL_LIMIT = 1000;
   localparam int MIX_ITEMS   = 650;
   localparam int SEGMENT     = 50;

   // One expected response beat, in the order the fields are checked.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ID_W-1:0]   id;
      logic [COST_W-1:0] cost;
      logic [OCC_W-1:0]  occ;
   } job_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [15:0] job_id, [31:16] job_cost
   logic [0:0]  req_tuser = '0;   // [0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [15:0] out_id, [31:16] out_cost, [39:32] occupancy
   logic [1:0]  rsp_tuser;        // [1:0] status

   // Shadow copy of the sorted queue, head at index 0.
   entry_type     shadow_store [DEPTH];
   int            shadow_count = 0;
   job_reply_type pending_replies [$];

   // When set, neither side inserts idle cycles between beats.
   bit no_idle = 1'b0;

   int mismatches = 0;
   int enq_total = 0;
   int deq_total = 0;
   int full_rejects = 0;
   int empty_rejects = 0;
   int peak_count = 0;
   int replies_seen = 0;

   sorted_priority_queue_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one accepted request to the shadow queue and returns the response
   // the block must give for it.
   function automatic job_reply_type apply_request(logic kind, logic [ID_W-1:0] id,
                                                   logic [COST_W-1:0] cost);
      job_reply_type reply;
      int            slot;
      reply = '0;
      slot  = 0;
      if (kind == REQ_ENQ) begin
         enq_total++;
         if (shadow_count >= DEPTH) begin
            reply.status = ST_FULL;
            full_rejects++;
         end else begin
            // Equal costs go behind the ones already stored, so ties leave in
            // arrival order.
            while (slot < shadow_count && shadow_store[slot].cost <= cost) slot++;
            for (int i = shadow_count; i > slot; i--) shadow_store[i] = shadow_store[i-1];
            shadow_store[slot].id   = id;
            shadow_store[slot].cost = cost;
            shadow_count++;
            reply.status = ST_OK;
         end
      end else begin
         deq_total++;
         if (shadow_count == 0) begin
            reply.status = ST_EMPTY;
            empty_rejects++;
         end else begin
            reply.status = ST_OK;
            reply.id     = shadow_store[0].id;
            reply.cost   = shadow_store[0].cost;
            for (int i = 0; i < shadow_count - 1; i++) shadow_store[i] = shadow_store[i+1];
            shadow_count--;
         end
      end
      reply.occ = OCC_W'(shadow_count);
      if (shadow_count > peak_count) peak_count = shadow_count;
      return reply;
   endfunction

   // Sends one request beat. It is entered at a falling edge and returns at
   // the falling edge after the beat was accepted. When no gap is drawn the
   // valid stays high from the previous beat, so it is never dropped and
   // raised in the same step.
   task automatic send_request(input logic kind, input logic [ID_W-1:0] id,
                               input logic [COST_W-1:0] cost);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {cost, id};
      do @(posedge clock); while (!req_tready);
      pending_replies.push_back(apply_request(kind, id, cost));
      @(negedge clock);
   endtask

   // Costs are drawn so that ties and the ends of the range come up often,
   // while every bit still toggles.
   function automatic logic [COST_W-1:0] draw_cost();
      logic [COST_W-1:0] cost;
      case ($urandom_range(0, 3))
         0: begin
            cost = COST_W'($urandom_range(0, 7));
         end
         1: begin
            case ($urandom_range(0, 3))
               0: cost = '0;
               1: cost = '1;
               2: cost = 16'h7fff;
               default: cost = 16'h8000;
            endcase
         end
         default: begin
            cost = COST_W'($urandom);
         end
      endcase
      return cost;
   endfunction

   task automatic send_random(input int enq_percent);
      logic kind;
      kind = ($urandom_range(1, 100) <= enq_percent) ? REQ_ENQ : REQ_DEQ;
      send_request(kind, ID_W'($urandom), draw_cost());
   endtask

   // Waits until every response owed so far has come back.
   task automatic wait_for_replies();
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // Response side: a random stall before each beat, none while no_idle is set.
   initial begin
      int stall;
      while (reset) @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Compares every accepted response beat with the oldest expected one.
   always @(posedge clock) begin
      job_reply_type want;
      job_reply_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         replies_seen++;
         got.status = rsp_tuser;
         got.id     = rsp_tdata[15:0];
         got.cost   = rsp_tdata[31:16];
         got.occ    = rsp_tdata[39:32];
         if (pending_replies.size() == 0) begin
            if (mismatches < 10)
               $display("Unexpected response beat: status=%0d id=%h cost=%h occ=%0d",
                        got.status, got.id, got.cost, got.occ);
            mismatches++;
         end else begin
            want = pending_replies.pop_front();
            if (got.status !== want.status || got.id !== want.id ||
                got.cost !== want.cost || got.occ !== want.occ) begin
               if (mismatches < 10)
                  $display("Mismatch on response %0d: expected status=%0d id=%h cost=%h occ=%0d, got status=%0d id=%h cost=%h occ=%0d",
                           replies_seen, want.status, want.id, want.cost, want.occ,
                           got.status, got.id, got.cost, got.occ);
               mismatches++;
            end
         end
      end
   end

   // Ends the run if neither side moves a beat for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Watchdog expired with %0d responses outstanding.", pending_replies.size());
      $display("DONE: errors detected");
      $finish;
   end

   // Two dequeues on the freshly reset queue must report empty; their id and cost
   // fields are don't-care and are driven to all ones, then to all zeros.
   task automatic test_empty_dequeue();
      send_request(REQ_DEQ, '1, '1);
      send_request(REQ_DEQ, '0, '0);
   endtask

   // Extreme ids and costs, ties at both ends of the cost range and in the
   // middle, then a full drain that must come out in cost order with ties in
   // arrival order, ending in one more empty dequeue.
   task automatic test_order_and_ties();
      send_request(REQ_ENQ, 16'h0001, 16'h8000);
      send_request(REQ_ENQ, 16'hffff, 16'h0000);
      send_request(REQ_ENQ, 16'h0000, 16'hffff);
      send_request(REQ_ENQ, 16'haaaa, 16'h8000);
      send_request(REQ_ENQ, 16'h5555, 16'h0000);
      send_request(REQ_ENQ, 16'h1234, 16'h7fff);
      send_request(REQ_ENQ, 16'h4321, 16'h8001);
      send_request(REQ_ENQ, 16'hfffe, 16'hffff);
      repeat (8) send_request(REQ_DEQ, 16'h0000, 16'h0000);
      send_request(REQ_DEQ, '1, '1);
   endtask

   // Mostly enqueues with random content until the queue is full and several
   // inserts have been turned away.
   task automatic test_fill_past_full();
      int rejects_at_start;
      rejects_at_start = full_rejects;
      no_idle = 1'b0;
      while (full_rejects - rejects_at_start < 4) send_random(88);
   endtask

   // Mostly dequeues back-to-back until the queue has run dry several times.
   task automatic test_drain_past_empty();
      int rejects_at_start;
      rejects_at_start = empty_rejects;
      no_idle = 1'b1;
      while (empty_rejects - rejects_at_start < 4) send_random(12);
      no_idle = 1'b0;
   endtask

   // Segments of mixed traffic, each with its own enqueue bias, some of them
   // without any idle cycles on either side.
   task automatic test_random_mix();
      int bias;
      for (int seg = 0; seg < MIX_ITEMS / SEGMENT; seg++) begin
         case ($urandom_range(0, 2))
            0: bias = 25;
            1: bias = 50;
            default: bias = 80;
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (SEGMENT) send_random(bias);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_dequeue();
      test_order_and_ties();
      test_fill_past_full();
      test_drain_past_empty();
      test_random_mix();

      req_tvalid <= 1'b0;
      wait_for_replies();
      repeat (5) @(posedge clock);
      if (pending_replies.size() != 0) begin
         $display("%0d expected responses never arrived.", pending_replies.size());
         mismatches++;
      end

      $display("Sent %0d enqueues and %0d dequeues; %0d inserts rejected as full,",
               enq_total, deq_total, full_rejects);
      $display("%0d dequeues found the queue empty, peak occupancy %0d, %0d mismatches.",
               empty_rejects, peak_count, mismatches);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
